/* hw/rtl/mfre_pkg.sv */
// Shared types and constants for the median filtered rate estimator.
// No dependencies; used by mfre_div and median_filtered_rate_estimator.
package mfre_pkg;

    localparam int unsigned GAP_W        = 32;
    localparam int unsigned SEQ_W        = 4;
    localparam int unsigned RECV_W       = 24;
    localparam int unsigned CAP_W        = 25;
    localparam int unsigned FILTER_SHIFT = 3;
    localparam int unsigned US_PER_SEC   = 1000000;
    localparam int unsigned US_PER_SEC_W = 20;
    localparam int unsigned CAP_SATURATE = 17000000;
    localparam int unsigned RECV_MAX     = 24'hFFFFFF;

    localparam logic [SEQ_W-1:0] PROBE_SEQ = 4'h1;

    localparam logic REQ_ARRIVAL  = 1'b0;
    localparam logic REQ_ESTIMATE = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_CAND  = 7'b0000100,
        S_LATCH = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_FILT  = 7'b0100000,
        S_DIV   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* hw/rtl/mfre_ram.sv */
// Generic single write, single read RAM with registered read data.
// No dependencies.
module mfre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/mfre_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on mfre_pkg for the status struct.
module mfre_div #(
    parameter int DVD_W = 26,
    parameter int DVS_W = 39
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DVD_W-1:0]     i_dividend,
    input  logic [DVS_W-1:0]     i_divisor,
    output logic [DVD_W-1:0]     o_quotient,
    output mfre_pkg::t_div_stat  o_stat
);

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign rem_sh = {r_rem, r_q[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= CW'(DVD_W);
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits DVS_W bits
            r_rem <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], ge};
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_quotient  = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* hw/rtl/median_filtered_rate_estimator.sv */
// Median filtered packet rate estimator, top level.
// Depends on mfre_pkg, mfre_ram and mfre_div.
//
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------------
//  in      | i_in_valid / o_in_ready    | i_req_type, i_time_us, i_seq_low
//  out     | o_out_valid / i_out_ready  | o_recv_rate, o_recv_rate_valid,
//          |                            | o_link_capacity, o_capacity_valid
//
// An arrival takes effect on its transfer: the gap rings and timestamps update at the edge.
// An estimate request runs per window (n gaps held): median select through one RAM read
// port and one comparator, filtering, and the shared restoring divider; an empty window
// skips all three.
// Reset clears fills, heads and timestamp valid flags; gap rings need no clearing.
// A result waits in the output register; arrivals keep transferring meanwhile, a new
// request waits until the result is taken.
module median_filtered_rate_estimator #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [mfre_pkg::GAP_W-1:0]    i_time_us,
    input  logic [mfre_pkg::SEQ_W-1:0]    i_seq_low,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mfre_pkg::RECV_W-1:0]   o_recv_rate,
    output logic                          o_recv_rate_valid,
    output logic [mfre_pkg::CAP_W-1:0]    o_link_capacity,
    output logic                          o_capacity_valid
);

    localparam int GW    = mfre_pkg::GAP_W;
    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int NW    = $clog2(WINDOW_DEPTH + 1);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 2);
    localparam int SUM_W = GW + CNT_W;
    localparam int DVD_W = CNT_W + mfre_pkg::US_PER_SEC_W;

    mfre_pkg::t_state r_state, n_state;

    logic [NW-1:0]    r_fill_a, r_fill_p;
    logic [AW-1:0]    r_head_a, r_head_p;
    logic [GW-1:0]    r_last_a, r_last_p;
    logic             r_last_a_valid, r_last_p_valid;

    logic             r_win;
    logic [NW-1:0]    r_i, r_j;
    logic             r_pend;
    logic [NW-1:0]    r_less, r_le;
    logic [GW-1:0]    r_cand, r_med;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_sum;

    logic             r_out_valid;
    logic [mfre_pkg::RECV_W-1:0] r_recv_rate;
    logic             r_recv_valid;
    logic [mfre_pkg::CAP_W-1:0]  r_cap_rate;
    logic             r_cap_valid;

    logic             in_fire, is_probe;
    logic             we_a, we_p;
    logic [AW-1:0]    rd_addr;
    logic [GW-1:0]    rd_a, rd_p, rdata;
    logic [NW-1:0]    n_cur, k_rank;
    logic             scan_end, found;
    logic [GW+2:0]    upper;
    logic [GW-1:0]    lower;
    logic             pass;
    logic             div_start;
    logic [DVD_W-1:0] dividend, quotient;
    mfre_pkg::t_div_stat div_stat;
    logic             sum_zero;
    logic [mfre_pkg::CAP_W-1:0]  cap_rate;
    logic [mfre_pkg::RECV_W-1:0] recv_rate;
    logic             recv_ok;

    // Input side.
    assign o_in_ready = (r_state == mfre_pkg::S_IDLE) &&
                        (i_req_type == mfre_pkg::REQ_ARRIVAL || !r_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;
    assign is_probe   = i_seq_low == mfre_pkg::PROBE_SEQ;
    assign we_a       = in_fire && i_req_type == mfre_pkg::REQ_ARRIVAL && r_last_a_valid;
    assign we_p       = in_fire && i_req_type == mfre_pkg::REQ_ARRIVAL && is_probe &&
                        r_last_p_valid;

    assign rd_addr = (r_state == mfre_pkg::S_CAND) ? r_i[AW-1:0] : r_j[AW-1:0];

    mfre_ram #(.WIDTH(GW), .DEPTH(WINDOW_DEPTH)) u_ram_arrival (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_head_a),
        .i_wdata (i_time_us - r_last_a),
        .i_raddr (rd_addr),
        .o_rdata (rd_a)
    );

    mfre_ram #(.WIDTH(GW), .DEPTH(WINDOW_DEPTH)) u_ram_probe (
        .i_clk   (i_clk),
        .i_we    (we_p),
        .i_waddr (r_head_p),
        .i_wdata (i_time_us - r_last_p),
        .i_raddr (rd_addr),
        .o_rdata (rd_p)
    );

    assign rdata    = r_win ? rd_p : rd_a;
    assign n_cur    = r_win ? r_fill_p : r_fill_a;
    assign k_rank   = n_cur >> 1;
    assign scan_end = (r_j == n_cur) && !r_pend;
    // candidate is the median when rank n/2 falls within its run of equal values
    assign found    = (r_less <= k_rank) && (k_rank < r_le);

    assign upper = {r_med, 3'b000};
    assign lower = r_med >> mfre_pkg::FILTER_SHIFT;
    assign pass  = ({3'b000, rdata} < upper) && (rdata > lower);

    assign div_start = (r_state == mfre_pkg::S_FILT) && scan_end;
    assign dividend  = DVD_W'(r_count) * DVD_W'(mfre_pkg::US_PER_SEC);

    mfre_div #(.DVD_W(DVD_W), .DVS_W(SUM_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_sum),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    // Clamp the quotient; a zero sum saturates.
    assign sum_zero = r_sum == '0;
    always_comb begin
        if (sum_zero || 64'(quotient) > 64'(mfre_pkg::CAP_SATURATE)) begin
            cap_rate = mfre_pkg::CAP_W'(mfre_pkg::CAP_SATURATE);
        end else begin
            cap_rate = mfre_pkg::CAP_W'(quotient);
        end
        if (64'(cap_rate) > 64'(mfre_pkg::RECV_MAX)) begin
            recv_rate = mfre_pkg::RECV_W'(mfre_pkg::RECV_MAX);
        end else begin
            recv_rate = cap_rate[mfre_pkg::RECV_W-1:0];
        end
    end
    assign recv_ok = r_count > CNT_W'(k_rank);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mfre_pkg::S_IDLE: begin
                if (in_fire && i_req_type == mfre_pkg::REQ_ESTIMATE) begin
                    n_state = mfre_pkg::S_CHECK;
                end
            end
            mfre_pkg::S_CHECK: begin
                if (n_cur != '0) begin
                    n_state = mfre_pkg::S_CAND;
                end else if (r_win) begin
                    n_state = mfre_pkg::S_IDLE;
                end
            end
            mfre_pkg::S_CAND:  n_state = mfre_pkg::S_LATCH;
            mfre_pkg::S_LATCH: n_state = mfre_pkg::S_SCAN;
            mfre_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = found ? mfre_pkg::S_FILT : mfre_pkg::S_CAND;
                end
            end
            mfre_pkg::S_FILT: begin
                if (scan_end) begin
                    n_state = mfre_pkg::S_DIV;
                end
            end
            mfre_pkg::S_DIV: begin
                if (div_stat.done) begin
                    n_state = r_win ? mfre_pkg::S_IDLE : mfre_pkg::S_CHECK;
                end
            end
            default: n_state = mfre_pkg::S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= mfre_pkg::S_IDLE;
            r_fill_a       <= '0;
            r_fill_p       <= '0;
            r_head_a       <= '0;
            r_head_p       <= '0;
            r_last_a_valid <= 1'b0;
            r_last_p_valid <= 1'b0;
            r_out_valid    <= 1'b0;
            r_win          <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire && i_req_type == mfre_pkg::REQ_ARRIVAL) begin
                r_last_a_valid <= 1'b1;
                if (is_probe) begin
                    r_last_p_valid <= 1'b1;
                end
            end
            if (we_a) begin
                r_head_a <= (r_head_a == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head_a + AW'(1);
                if (r_fill_a != NW'(WINDOW_DEPTH)) begin
                    r_fill_a <= r_fill_a + NW'(1);
                end
            end
            if (we_p) begin
                r_head_p <= (r_head_p == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head_p + AW'(1);
                if (r_fill_p != NW'(WINDOW_DEPTH)) begin
                    r_fill_p <= r_fill_p + NW'(1);
                end
            end
            if (in_fire && i_req_type == mfre_pkg::REQ_ESTIMATE) begin
                r_win <= 1'b0;
            end
            // finish a window: advance to the probe window or present the result
            if ((r_state == mfre_pkg::S_CHECK && n_cur == '0) ||
                (r_state == mfre_pkg::S_DIV && div_stat.done)) begin
                if (r_win) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_win <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (in_fire && i_req_type == mfre_pkg::REQ_ARRIVAL) begin
            r_last_a <= i_time_us;
            if (is_probe) begin
                r_last_p <= i_time_us;
            end
        end
        case (r_state)
            mfre_pkg::S_CHECK: begin
                r_i <= '0;
                if (n_cur == '0) begin
                    if (r_win) begin
                        r_cap_rate  <= '0;
                        r_cap_valid <= 1'b0;
                    end else begin
                        r_recv_rate  <= '0;
                        r_recv_valid <= 1'b0;
                    end
                end
            end
            mfre_pkg::S_LATCH: begin
                r_cand <= rdata;
                r_j    <= '0;
                r_pend <= 1'b0;
                r_less <= '0;
                r_le   <= '0;
            end
            mfre_pkg::S_SCAN: begin
                if (r_j != n_cur) begin
                    r_j    <= r_j + NW'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                if (r_pend) begin
                    if (rdata < r_cand) begin
                        r_less <= r_less + NW'(1);
                    end
                    if (rdata <= r_cand) begin
                        r_le <= r_le + NW'(1);
                    end
                end
                if (scan_end) begin
                    if (found) begin
                        r_med   <= r_cand;
                        r_j     <= '0;
                        r_count <= r_win ? CNT_W'(1) : '0;
                        r_sum   <= r_win ? SUM_W'(r_cand) : '0;
                    end else begin
                        r_i <= r_i + NW'(1);
                    end
                end
            end
            mfre_pkg::S_FILT: begin
                if (r_j != n_cur) begin
                    r_j    <= r_j + NW'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                if (r_pend && pass) begin
                    r_count <= r_count + CNT_W'(1);
                    r_sum   <= r_sum + SUM_W'(rdata);
                end
            end
            mfre_pkg::S_DIV: begin
                if (div_stat.done) begin
                    if (r_win) begin
                        r_cap_rate  <= cap_rate;
                        r_cap_valid <= 1'b1;
                    end else begin
                        r_recv_rate  <= recv_ok ? recv_rate : '0;
                        r_recv_valid <= recv_ok;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_recv_rate       = r_recv_rate;
    assign o_recv_rate_valid = r_recv_valid;
    assign o_link_capacity   = r_cap_rate;
    assign o_capacity_valid  = r_cap_valid;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mfre_pkg::S_IDLE) |-> !r_out_valid)
        else $error("estimate in progress while a result is pending");

    a_cand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfre_pkg::S_CAND) |-> (r_i < n_cur))
        else $error("median select ran past the window");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == mfre_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    a_head_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill_a < NW'(WINDOW_DEPTH)) |-> (r_head_a == r_fill_a[AW-1:0]))
        else $error("arrival head and fill disagree before wrap");

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill_a <= NW'(WINDOW_DEPTH)) && (r_fill_p <= NW'(WINDOW_DEPTH)))
        else $error("window fill exceeds depth");
`endif

endmodule
